@@ rtl/ppap_pkg.sv @@
// ----------------------------------------------------------------------------
// ppap_pkg: shared definitions for the ping-pong audio playback block
// Widths, field layout of the stream words, input kinds, source codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ppap_pkg;

    localparam int MAX_FRAMES   = 1024;
    localparam int MAX_CHANNELS = 2;
    localparam int NUM_BLOCKS   = 2;
    localparam int STORE_DEPTH  = NUM_BLOCKS * MAX_FRAMES * MAX_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int FRAME_W      = $clog2(MAX_FRAMES);
    localparam int CHAN_W       = 1;
    localparam int POS_W        = 11;
    localparam int BF_W         = 11;
    localparam int NCH_W        = 2;
    localparam int SAMPLE_W     = 24;
    localparam int COUNT_W      = 32;
    localparam int MODE_W       = 2;
    localparam int SRC_W        = 2;

    // Input word layout
    localparam int IN_TDATA_W   = 40;
    localparam int IN_TUSER_W   = 3;
    // Output word layout
    localparam int OUT_TDATA_W  = 128;
    localparam int OUT_TUSER_W  = SRC_W;

    // Configuration register indexes
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 1'd1;
    localparam int CFG_DATA_W   = BF_W;

    localparam logic [BF_W-1:0]  BLOCK_FRAMES_RST = BF_W'(MAX_FRAMES);
    localparam logic [NCH_W-1:0] NUM_CHANNELS_RST = NCH_W'(MAX_CHANNELS);

    // Input kinds
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Source / active block codes
    localparam logic [SRC_W-1:0] SRC_NONE    = 2'd0;
    localparam logic [SRC_W-1:0] SRC_FIRST   = 2'd1;
    localparam logic [SRC_W-1:0] SRC_SECOND  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_INVALID = 2'd3;

    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic emit;       // load a result into the output register
        logic emit_ch1;   // the result loaded is channel one
    } t_dp_cmd;

    typedef struct packed {
        logic in_play;    // pending input word is a play item
        logic two_ch;     // frame in progress carries two channels
        logic out_free;   // output register can take a result now
    } t_dp_status;

endpackage

@@ rtl/ppap_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppap_ctrl: play sequencer
// Takes input words and, for a play item, steps the datapath through one
// result per channel as the output register frees up.
// ----------------------------------------------------------------------------
module ppap_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ppap_pkg::t_dp_status i_status,
    output ppap_pkg::t_dp_cmd   o_cmd
);
    import ppap_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CH0  = 2'd1;
    localparam logic [1:0] ST_CH1  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.emit     = 1'b0;
        o_cmd.emit_ch1 = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_play) begin
                        n_state = ST_CH0;
                    end
                end
            end
            ST_CH0: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.two_ch ? ST_CH1 : ST_IDLE;
                end
            end
            ST_CH1: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_ch1 = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/ppap_dp.sv @@
// ----------------------------------------------------------------------------
// ppap_dp: playback datapath
// Sample memory, fill flags, active block, play position, counters,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module ppap_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppap_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ppap_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [ppap_pkg::IN_TDATA_W-1:0]     i_in_tdata,
    input  logic [ppap_pkg::IN_TUSER_W-1:0]     i_in_tuser,
    input  logic                                i_in_tlast,
    input  ppap_pkg::t_dp_cmd                   i_cmd,
    output ppap_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [ppap_pkg::OUT_TDATA_W-1:0]    o_out_tdata,
    output logic [ppap_pkg::OUT_TUSER_W-1:0]    o_out_tuser,
    output logic                                o_out_tlast
);
    import ppap_pkg::*;

    // input fields
    logic [MODE_W-1:0]          in_mode;
    logic                       in_blk;
    logic [FRAME_W-1:0]         in_frame;
    logic [CHAN_W-1:0]          in_chan;
    logic [SAMPLE_W-1:0]        in_sample;
    logic                       in_batch;

    assign in_mode   = i_in_tuser[1:0];
    assign in_batch  = i_in_tuser[2];
    assign in_blk    = i_in_tdata[0];
    assign in_frame  = i_in_tdata[10:1];
    assign in_chan   = i_in_tdata[11];
    assign in_sample = i_in_tdata[35:12];

    // configuration
    logic [BF_W-1:0]  r_block_frames;
    logic [NCH_W-1:0] r_num_channels;
    logic [BF_W-1:0]  frames_use;
    logic             two_ch_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_frames <= BLOCK_FRAMES_RST;
            r_num_channels <= NUM_CHANNELS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_FRAMES: r_block_frames <= i_cfg_data;
                CFG_NUM_CHANNELS: r_num_channels <= i_cfg_data[NCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_block_frames == '0) begin
            frames_use = BF_W'(1);
        end else if (r_block_frames > BF_W'(MAX_FRAMES)) begin
            frames_use = BF_W'(MAX_FRAMES);
        end else begin
            frames_use = r_block_frames;
        end
    end

    assign two_ch_use = (r_num_channels >= NCH_W'(2));

    // player state
    logic [1:0]          r_needs_fill, n_needs_fill;
    logic [SRC_W-1:0]    r_active, n_active;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [COUNT_W-1:0]  r_played, n_played;
    logic [COUNT_W-1:0]  r_skipped, n_skipped;
    logic [COUNT_W-1:0]  r_loaded, n_loaded;

    // frame in progress
    logic [SRC_W-1:0]    r_src;
    logic [FRAME_W-1:0]  r_frame;
    logic                r_two_ch;

    logic [SRC_W-1:0]    act_start;
    logic [SRC_W-1:0]    src;
    logic [POS_W-1:0]    pos_inc;
    logic                load_ok;
    logic                load_write;
    logic                play_acc;

    assign play_acc = i_cmd.accept && (in_mode == MODE_PLAY);

    always_comb begin
        act_start = r_active;
        if (in_batch && (r_active == SRC_NONE)) begin
            priority if (!r_needs_fill[0]) begin
                act_start = SRC_FIRST;
            end else if (!r_needs_fill[1]) begin
                act_start = SRC_SECOND;
            end else begin
                act_start = SRC_NONE;
            end
        end
    end

    assign src = (act_start == SRC_FIRST || act_start == SRC_SECOND) ? act_start : SRC_NONE;
    assign pos_inc = r_pos + POS_W'(1);
    assign load_ok = r_needs_fill[in_blk];
    assign load_write = i_cmd.accept && (in_mode == MODE_LOAD) && load_ok
                        && ({1'b0, in_frame} < frames_use)
                        && ((in_chan == 1'b0) || two_ch_use);

    always_comb begin
        n_needs_fill = r_needs_fill;
        n_active     = r_active;
        n_pos        = r_pos;
        n_played     = r_played;
        n_skipped    = r_skipped;
        n_loaded     = r_loaded;
        if (i_cmd.accept) begin
            unique case (in_mode)
                MODE_LOAD: begin
                    if (load_ok && i_in_tlast) begin
                        n_needs_fill[in_blk] = 1'b0;
                        n_loaded = r_loaded + COUNT_W'(frames_use);
                    end
                end
                MODE_PLAY: begin
                    if (src != SRC_NONE) begin
                        n_played = r_played + COUNT_W'(1);
                        if (pos_inc >= frames_use) begin
                            // block done: mark for refill, move on if the other is full
                            n_pos = '0;
                            if (src == SRC_FIRST) begin
                                n_needs_fill[0] = 1'b1;
                                n_active = r_needs_fill[1] ? SRC_NONE : SRC_SECOND;
                            end else begin
                                n_needs_fill[1] = 1'b1;
                                n_active = r_needs_fill[0] ? SRC_NONE : SRC_FIRST;
                            end
                        end else begin
                            n_pos    = pos_inc;
                            n_active = act_start;
                        end
                    end else begin
                        n_skipped = r_skipped + COUNT_W'(1);
                        n_pos     = '0;
                        n_active  = (act_start == SRC_INVALID) ? act_start : SRC_NONE;
                    end
                end
                MODE_CLEAR: begin
                    n_played  = '0;
                    n_skipped = '0;
                    n_loaded  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needs_fill <= 2'b11;
            r_active     <= SRC_NONE;
            r_pos        <= '0;
            r_played     <= '0;
            r_skipped    <= '0;
            r_loaded     <= '0;
        end else begin
            r_needs_fill <= n_needs_fill;
            r_active     <= n_active;
            r_pos        <= n_pos;
            r_played     <= n_played;
            r_skipped    <= n_skipped;
            r_loaded     <= n_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (play_acc) begin
            r_src    <= src;
            r_frame  <= r_pos[FRAME_W-1:0];
            r_two_ch <= two_ch_use;
        end
    end

    // sample memory: layout block, frame, channel
    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_en;

    assign wr_addr = {in_blk, in_frame, in_chan};
    assign rd_en   = play_acc || (i_cmd.emit && !i_cmd.emit_ch1);
    assign rd_addr = play_acc ? {src[1], r_pos[FRAME_W-1:0], 1'b0}
                              : {r_src[1], r_frame, 1'b1};

    always_ff @(posedge i_clk) begin
        if (load_write) begin
            mem[wr_addr] <= in_sample;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // output register
    logic                    r_out_valid;
    logic [SAMPLE_W-1:0]     r_out_sample;
    logic                    r_out_chan;
    logic                    r_out_last;
    logic [SRC_W-1:0]        r_out_src;
    logic [COUNT_W-1:0]      r_out_played;
    logic [COUNT_W-1:0]      r_out_skipped;
    logic [COUNT_W-1:0]      r_out_loaded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample  <= (r_src != SRC_NONE) ? r_rdata : '0;
            r_out_chan    <= i_cmd.emit_ch1;
            r_out_last    <= i_cmd.emit_ch1 || !r_two_ch;
            r_out_src     <= r_src;
            r_out_played  <= r_played;
            r_out_skipped <= r_skipped;
            r_out_loaded  <= r_loaded;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {7'd0, r_out_loaded, r_out_skipped, r_out_played,
                          r_out_chan, r_out_sample};
    assign o_out_tuser = r_out_src;
    assign o_out_tlast = r_out_last;

    assign o_status.in_play  = (in_mode == MODE_PLAY);
    assign o_status.two_ch   = r_two_ch;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

@@ rtl/ping_pong_audio_playback.sv @@
// ----------------------------------------------------------------------------
// ping_pong_audio_playback: two-block ping-pong audio playback buffer
// Loads Q1.23 samples into two blocks and plays them back frame by frame.
// ----------------------------------------------------------------------------
// A loader writes samples one word at a time into whichever of the two blocks
// still needs a fill; the word flagged tlast marks that block full and adds
// the block length to the loaded-frame count. Each play word produces one
// frame: one output word per channel in use (one or two), taken from the
// active block, or zeros tagged as silence with the skip count bumped when no
// block is active. A finished block is marked for refill and play moves to
// the other block only when it is already full; an idle player picks up a
// full block only on a play word with batch_start set. A clear word zeroes
// the three counters. Load, clear and unused words produce nothing. A play
// word is accepted and then yields one result per channel, each loaded into
// the output register as it frees up; this sequence is set by the single
// read port of the 4096 x 24 sample memory, read once per channel, and the
// single output register. The next word is accepted while the last result
// of a frame still waits in the output register. The sample memory has no
// reset; playing a location never loaded returns an undefined sample.
// Configuration writes must only happen while the block is idle.
// ----------------------------------------------------------------------------
module ping_pong_audio_playback (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [ppap_pkg::CFG_IDX_W-1:0]      i_cfg_idx,   // 0 block_frames, 1 num_channels
    input  logic [ppap_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // block_select[0], frame_index[10:1], channel_index[11], sample_value[35:12], zeros
    input  logic [ppap_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode[1:0], batch_start[2]
    input  logic [ppap_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                                s_axis_tlast,  // block_last
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_sample[23:0], out_channel[24], played_count[56:25],
    // skipped_count[88:57], loaded_count[120:89], zeros
    output logic [ppap_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // source_block[1:0]
    output logic [ppap_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast   // frame_last
);
    import ppap_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence accept and per-channel emits
    ppap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold samples, player state, counters and the output register
    ppap_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_in_tlast  (s_axis_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser),
        .o_out_tlast (m_axis_tlast)
    );

endmodule

@@ rtl/ppap_chk.sv @@
// ----------------------------------------------------------------------------
// ppap_chk: port-level checks for the playback buffer
// Watches the stream ports over time and flags behavior the block must
// never show.
// ----------------------------------------------------------------------------
module ppap_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [ppap_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ppap_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic [ppap_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    input  logic                                m_axis_tlast
);
    import ppap_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // a word that makes no result frees the input side at once
    a_quick_nonplay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] != MODE_PLAY) |=> s_axis_tready)
        else $error("input stalled after a load or clear word");

    // silence carries zero samples
    a_silence_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == SRC_NONE) |-> (m_axis_tdata[SAMPLE_W-1:0] == '0))
        else $error("silent word carries a nonzero sample");

    // channel one always closes its frame
    a_ch1_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[SAMPLE_W] |-> m_axis_tlast)
        else $error("channel one word without frame_last");

    // no source code beyond the second block
    a_src_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != SRC_INVALID))
        else $error("invalid source_block code");

endmodule

bind ping_pong_audio_playback ppap_chk u_ppap_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
